// ===== rtl/pctd_pkg.sv =====
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared widths and the command and status groups that pass between the
// controller and the datapath of the trial-division prime counter.
// ----------------------------------------------------------------------------
package pctd_pkg;

  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 16;

  // Magnitude bits of a non-negative value.
  localparam int MAG_BITS = VALUE_BITS - 1;
  // Divisor width: holds the first divisor whose square exceeds the value.
  localparam int D_BITS   = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS  = 2 * D_BITS;
  // Bit counter of the serial remainder unit.
  localparam int BIT_W    = $clog2(MAG_BITS);

  typedef struct packed {
    logic load;      // take a new transaction into the datapath
    logic div_init;  // start a remainder calculation for the current divisor
    logic div_step;  // one restoring step of the remainder
    logic next_div;  // advance divisor and its square
    logic set_prime; // mark the current value as prime
    logic emit;      // write the result register
  } pctd_cmd_t;

  typedef struct packed {
    logic below_two; // negative, zero or one
    logic sq_over;   // divisor squared exceeds the value
    logic div_done;  // the remainder step now running is the last one
    logic rem_zero;  // remainder is zero
    logic out_busy;  // result register is full and not being taken
  } pctd_stat_t;

endpackage

// ===== rtl/pctd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pctd_ctrl
// Controller of the prime counter: sequences the divisor loop and the
// bit-serial remainder unit, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pctd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pctd_pkg::pctd_stat_t stat,
  output pctd_pkg::pctd_cmd_t  cmd
);
  import pctd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TEST   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_REM    = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.below_two) begin
          state_next = S_RESULT;
        end else if (stat.sq_over) begin
          cmd.set_prime = 1'b1;
          state_next    = S_RESULT;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_REM;
        end
      end
      S_REM: begin
        if (stat.rem_zero) begin
          state_next = S_RESULT;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/pctd_dp.sv =====
// ----------------------------------------------------------------------------
// pctd_dp
// Datapath of the prime counter: value and divisor registers, an
// incrementally kept divisor square, a one-bit-per-cycle restoring remainder
// unit, the running prime count and the output register.
// ----------------------------------------------------------------------------
module pctd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [pctd_pkg::VALUE_BITS-1:0] value,
  input  logic                                 last,
  input  pctd_pkg::pctd_cmd_t                  cmd,
  output pctd_pkg::pctd_stat_t                 stat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 is_prime,
  output logic [pctd_pkg::COUNT_BITS-1:0]      prime_count,
  output logic                                 done_res
);
  import pctd_pkg::*;

  logic [VALUE_BITS-1:0] val;
  logic                  lst;
  logic [D_BITS-1:0]     d;
  logic [SQ_BITS-1:0]    sq;
  logic [MAG_BITS-1:0]   shf;
  logic [D_BITS-1:0]     rem;
  logic [BIT_W-1:0]      bitcnt;
  logic                  prime;
  logic [COUNT_BITS-1:0] running_count;
  logic [COUNT_BITS-1:0] count_next;

  logic [MAG_BITS-1:0]   mag;
  logic [D_BITS:0]       trial;
  logic [D_BITS:0]       diff;
  logic [D_BITS-1:0]     rem_next;

  assign mag = val[MAG_BITS-1:0];

  // One restoring step: bring in the next value bit, subtract when it fits.
  assign trial = {rem, shf[MAG_BITS-1]};
  assign diff  = trial - {1'b0, d};
  always_comb begin
    if (trial >= {1'b0, d}) begin
      rem_next = diff[D_BITS-1:0];
    end else begin
      rem_next = trial[D_BITS-1:0];
    end
  end

  always_comb begin
    count_next = running_count;
    if (prime && (running_count != {COUNT_BITS{1'b1}})) begin
      count_next = running_count + COUNT_BITS'(1);
    end
  end

  assign stat.below_two = val[VALUE_BITS-1] || (mag < MAG_BITS'(2));
  assign stat.sq_over   = sq > SQ_BITS'(mag);
  assign stat.div_done  = (bitcnt == '0);
  assign stat.rem_zero  = (rem == '0);
  assign stat.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val   <= value;
      lst   <= last;
      d     <= D_BITS'(2);
      sq    <= SQ_BITS'(4);
      prime <= 1'b0;
    end
    if (cmd.set_prime) begin
      prime <= 1'b1;
    end
    if (cmd.div_init) begin
      shf    <= mag;
      rem    <= '0;
      bitcnt <= BIT_W'(MAG_BITS - 1);
    end
    if (cmd.div_step) begin
      shf    <= shf << 1;
      rem    <= rem_next;
      bitcnt <= bitcnt - BIT_W'(1);
    end
    if (cmd.next_div) begin
      d  <= d + D_BITS'(1);
      sq <= sq + SQ_BITS'({d, 1'b1});
    end
    if (cmd.emit) begin
      is_prime    <= prime;
      prime_count <= count_next;
      done_res    <= lst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      running_count <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid     <= 1'b1;
        running_count <= lst ? '0 : count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/prime_counter_trial_division.sv =====
// Each accepted value is first checked against two; values below two go
// straight to the result. Otherwise each divisor takes one bound check, 31
// remainder steps and one zero check, until the bound stops the search or
// the divisor divides the value; a large prime walks the most divisors.
// Throughput: one transaction at a time, set by the bit-serial remainder unit.
// Reset clears the controller, the running count and the result valid flag.
// ----------------------------------------------------------------------------
// prime_counter_trial_division
// Tests each signed input value for primality by trial division and reports
// a prime flag, the saturating running count of primes in the current array
// and the end-of-array mark.
// ----------------------------------------------------------------------------
module prime_counter_trial_division (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [pctd_pkg::VALUE_BITS-1:0] value,
  input  logic                                   last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   is_prime,
  output logic [pctd_pkg::COUNT_BITS-1:0]        prime_count,
  output logic                                   done_res
);
  import pctd_pkg::*;

  // The controller walks the divisors 2, 3, 4, ... and stops either when
  // the square of the divisor exceeds the value (the value is prime) or when
  // a remainder comes out zero (the value is composite). The square is kept
  // by adding 2d+1 on each advance, so no multiplier is needed, and the
  // remainder is formed one value bit per cycle by restoring subtraction.
  //
  // The result sits in an output register. Once it has been written, the
  // input side is ready again, so the next transaction is being worked on
  // while the previous result still waits to be taken.

  pctd_cmd_t  cmd;
  pctd_stat_t stat;

  pctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pctd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .last        (last),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_prime    (is_prime),
    .prime_count (prime_count),
    .done_res    (done_res)
  );

endmodule

// ===== test/tb_prime_counter_trial_division.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_counter_trial_division
// Self-checking bench for the trial-division prime counter. Transactions are
// driven over the valid/ready input channel, and a scoreboard predicts the
// prime flag, the saturating per-array count and the end-of-array mark. It
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct {
  logic                              prime;
  logic [pctd_pkg::COUNT_BITS-1:0]   count;
  logic                              done;
} prime_result_t;

class prime_scoreboard;
  logic [pctd_pkg::COUNT_BITS-1:0] running_count = '0;
  prime_result_t                   pending_results[$];
  int                              mismatches = 0;
  int                              checked = 0;

  // Trial division with the bound written as d <= n / d, so no product
  // can overflow.
  function bit prime_test(logic signed [pctd_pkg::VALUE_BITS-1:0] v);
    longint n;
    longint d;
    n = v;
    if (n < 2) return 1'b0;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_input(logic signed [pctd_pkg::VALUE_BITS-1:0] v, logic fin);
    prime_result_t r;
    r.prime = prime_test(v);
    if (r.prime && running_count != '1) running_count++;
    r.count = running_count;
    r.done  = fin;
    if (fin) running_count = '0;
    pending_results.push_back(r);
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_result(logic prime, logic [pctd_pkg::COUNT_BITS-1:0] count, logic done);
    prime_result_t want;
    if (pending_results.size() == 0) begin
      report("result arrived with no transaction outstanding");
    end else begin
      want = pending_results.pop_front();
      checked++;
      if (prime !== want.prime)
        report($sformatf("is_prime got %b want %b", prime, want.prime));
      if (count !== want.count)
        report($sformatf("prime_count got %0d want %0d", count, want.count));
      if (done !== want.done)
        report($sformatf("done_res got %b want %b", done, want.done));
    end
  endtask

  function int pending();
    return pending_results.size();
  endfunction
endclass

module tb_prime_counter_trial_division;
  import pctd_pkg::*;

  // The slowest item, the largest 32-bit prime, dominates the run; the random
  // transactions are far cheaper. This limit sits several times above the whole
  // correct run.
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int RANDOM_ITEMS_PER_PHASE = 20;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid;
  logic                           in_ready;
  logic signed [VALUE_BITS-1:0]   value;
  logic                           last;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           is_prime;
  logic [COUNT_BITS-1:0]          prime_count;
  logic                           done_res;

  prime_scoreboard sb = new;

  int unsigned cycles = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          random_sent = 0;

  prime_counter_trial_division dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_prime   (is_prime),
    .prime_count(prime_count),
    .done_res   (done_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver drops ready at random according to the current phase. With a
  // zero percentage it simply stays ready all the time.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Results are sampled at the clock edge, before any register in the block
  // has taken its new value, so the check never races the design.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(is_prime, prime_count, done_res);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Presents one transaction and returns at the edge where it is accepted.
  // It must be entered just after a rising edge. Valid is only lowered when an
  // idle gap is taken, so it is never lowered and raised in the same step.
  task send_item(logic signed [VALUE_BITS-1:0] v, logic fin);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_input(v, fin);
  endtask

  // Random values are weighted towards cheap cases: large magnitudes are
  // either negative or built with a small factor, so the division loop exits
  // early, while the small and medium ranges hold the primes.
  function logic signed [VALUE_BITS-1:0] random_value();
    int unsigned pick;
    int unsigned factor;
    int unsigned factors[6] = '{2, 3, 5, 7, 11, 13};
    pick = $urandom_range(99);
    if (pick < 15) begin
      return $urandom | 32'h8000_0000;
    end else if (pick < 25) begin
      return $urandom_range(0, 3);
    end else if (pick < 60) begin
      return $urandom_range(0, 20000);
    end else if (pick < 72) begin
      return $urandom_range(20001, 200000);
    end else begin
      factor = factors[$urandom_range(0, 5)];
      return $urandom_range(1, 32'h7fff_ffff / factor) * factor;
    end
  endfunction

  task run_random(int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_item(random_value(), ($urandom_range(7) == 0));
      random_sent++;
    end
  endtask

  initial begin
    in_valid = 1'b0;
    value    = '0;
    last     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed transactions: both ends of the signed range, the values below
    // two, perfect squares that sit exactly on the divisor bound, and a few
    // single-item arrays. The largest positive value is a prime and is by far
    // the slowest item of the run.
    send_item(32'sh8000_0000, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b0);
    send_item(4, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh7fff_fffe, 1'b1);
    send_item(5, 1'b1);
    send_item(9, 1'b1);
    send_item(49, 1'b0);
    send_item(121, 1'b0);
    send_item(97, 1'b0);
    send_item(7919, 1'b0);
    send_item(65537, 1'b0);
    send_item(32767, 1'b0);
    send_item(32'sh3fff_ffff, 1'b0);
    send_item(2147395600, 1'b0);
    send_item(-7, 1'b0);
    send_item(1, 1'b1);

    run_random(RANDOM_ITEMS_PER_PHASE);

    sender_idle_pct = 53;
    run_random(RANDOM_ITEMS_PER_PHASE);

    sender_idle_pct    = 0;
    receiver_stall_pct = 53;
    run_random(RANDOM_ITEMS_PER_PHASE);

    sender_idle_pct    = 32;
    receiver_stall_pct = 32;
    run_random(RANDOM_ITEMS_PER_PHASE);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Allow a little longer than the shortest latency for stray results.
    repeat (16) @(posedge clk);

    $display("Covered signed extremes, values below two, bound squares, short arrays");
    $display("and %0d random transactions over four pacing phases: %0d results, %0d mismatches.",
             random_sent, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
